### src/cds_pkg.sv
// cds_pkg: shared types, constants and calendar helper functions
// for the calendar date stepper. depends on nothing.
package cds_pkg;

    // year range and reset date
    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] YEAR_RESET = 14'd2000;
    localparam logic [6:0]  CENT_RESET = 7'd20;
    localparam logic [6:0]  YRLO_RESET = 7'd0;
    localparam logic [6:0]  YRLO_MAX   = 7'd99;
    localparam logic [3:0]  MONTH_MIN  = 4'd1;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [3:0]  MONTH_MAR  = 4'd3;
    localparam logic [3:0]  MONTH_JAN_Z = 4'd13;
    localparam logic [4:0]  DAY_MIN    = 5'd1;
    localparam logic [4:0]  DAY_MAX    = 5'd31;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // reciprocal constants: y / 100 for y < 10000, x / 7 for x < 1024
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [10:0] DIV7_MUL     = 11'd1171;
    localparam int          DIV7_SHIFT   = 13;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_NEXT = 2'd1,
        CMD_PREV = 2'd2,
        CMD_HOLD = 2'd3
    } cmd_t;

    // classified item passed from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [6:0]  yr_lo;
        logic [6:0]  cent;
    } op_t;

    // date after a step, with year split into century and year of century
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [6:0]  yr_lo;
        logic [6:0]  cent;
        logic        at_limit;
    } date_t;

    // leap rule from the low year bits, year of century and century
    function automatic logic is_leap(input logic [1:0] y_lo2, input logic [6:0] yr_lo,
                                     input logic [1:0] cent_lo2);
        return ((y_lo2 == 2'd0) && (yr_lo != 7'd0)) ||
               ((yr_lo == 7'd0) && (cent_lo2 == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // days in a common year before the first of the month
    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] n;
        case (month)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // zeller month term 13 * (m + 1) / 5, months counted 3..14
    function automatic logic [5:0] zeller_month_term(input logic [3:0] mz);
        logic [5:0] t;
        case (mz)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // full zeller sum before the mod 7, century term taken as +5J
    function automatic logic [9:0] zeller_sum(input logic [4:0] d, input logic [3:0] mz,
                                              input logic [6:0] kz, input logic [6:0] jz);
        return {5'b0, d} + {4'b0, zeller_month_term(mz)} + {3'b0, kz} +
               {5'b0, kz[6:2]} + {5'b0, jz[6:2]} + ({3'b0, jz} * 10'd5);
    endfunction

    // x / 7 by reciprocal multiply, exact for x < 1024
    function automatic logic [7:0] div7(input logic [9:0] x);
        logic [20:0] p;
        p = {11'b0, x} * {10'b0, DIV7_MUL};
        return p[DIV7_SHIFT+7:DIV7_SHIFT];
    endfunction

    function automatic logic [2:0] mod7(input logic [9:0] x);
        logic [7:0]  q;
        logic [10:0] r;
        q = div7(x);
        r = {1'b0, x} - ({q, 3'b0} - {3'b0, q});
        return r[2:0];
    endfunction

    // zeller residue to weekday, 1 monday .. 7 sunday
    function automatic logic [2:0] weekday_of(input logic [2:0] h);
        logic [2:0] wd;
        case (h)
            3'd0:    wd = 3'd6;
            3'd1:    wd = 3'd7;
            3'd2:    wd = 3'd1;
            3'd3:    wd = 3'd2;
            3'd4:    wd = 3'd3;
            3'd5:    wd = 3'd4;
            3'd6:    wd = 3'd5;
            default: wd = 3'd1;
        endcase
        return wd;
    endfunction

endpackage

### src/cds_if.sv
// cds_in_if / cds_out_if: valid-ready channels of the date stepper
// plain signal bundles, no dependencies
interface cds_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;

    modport source (output valid, cmd, load_day, load_month, load_year, input ready);
    modport sink   (input valid, cmd, load_day, load_month, load_year, output ready);
endinterface

interface cds_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [2:0]  weekday;
    logic [5:0]  week_of_year;
    logic        at_limit;

    modport source (output valid, out_day, out_month, out_year, weekday, week_of_year,
                    at_limit, input ready);
    modport sink   (input valid, out_day, out_month, out_year, weekday, week_of_year,
                    at_limit, output ready);
endinterface

### src/calendar_date_stepper_top.sv
// calendar_date_stepper_top: gregorian date counter with weekday and week number
// uses cds_pkg, cds_if, cds_front, cds_queue, cds_exec, cds_calc
//
// usage
//   in_ch beat: cmd (load, next day, previous day), load_day/month/year.
//   out_ch beat: one per input beat, in order: the date after the command,
//   weekday (1 monday .. 7 sunday), week of year and at_limit.
//   both channels move a beat on a clock edge with valid and ready high.
// throughput and path
//   one beat per cycle in and out, back to back, unless out_ch stalls.
//   a result passes through 2 front stages, the queue, the date register and
//   3 stages of weekday / week arithmetic. the date register updates once
//   per item, so the stepping path bounds the rate at one item per cycle.
// reset
//   date goes to 1 january 2000; all stages and the queue empty.
// stall
//   when out_ch.ready is low the pipeline fills; the queue keeps the front
//   taking beats until it is full, then in_ch.ready drops. no beat is lost.
module calendar_date_stepper_top
    import cds_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    cds_in_if.sink    in_ch,
    cds_out_if.source out_ch
);

    op_t   fr_op;
    logic  fr_valid;
    logic  fr_ready;
    op_t   q_op;
    logic  q_valid;
    logic  q_ready;
    date_t ex_dt;
    logic  ex_valid;
    logic  ex_ready;

    cds_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .op       (fr_op),
        .op_valid (fr_valid),
        .op_ready (fr_ready)
    );

    cds_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_op    (fr_op),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .rd_op    (q_op),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    cds_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (q_op),
        .op_valid (q_valid),
        .op_ready (q_ready),
        .dt       (ex_dt),
        .dt_valid (ex_valid),
        .dt_ready (ex_ready)
    );

    cds_calc u_calc (
        .clk      (clk),
        .rst_n    (rst_n),
        .dt       (ex_dt),
        .dt_valid (ex_valid),
        .dt_ready (ex_ready),
        .out_ch   (out_ch)
    );

endmodule

### src/cds_front.sv
// cds_front: accepts input beats, saturates load fields and splits the year
// two stages; uses cds_pkg and cds_in_if
module cds_front
    import cds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cds_in_if.sink    in_ch,
    output op_t       op,
    output logic      op_valid,
    input  logic      op_ready
);

    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    logic [4:0]  s1_day_reg;
    logic [3:0]  s1_month_reg;
    logic [13:0] s1_year_reg;
    logic [6:0]  s1_cent_reg;
    logic        s2_valid_reg;
    op_t         s2_op_reg;

    logic        s1_ready;
    logic        s2_ready;
    logic [13:0] year_next;
    logic [3:0]  month_next;
    logic [26:0] cent_prod;
    logic [13:0] hund;
    logic [13:0] yr_diff;
    logic [6:0]  yr_lo;
    logic        leap;
    logic [4:0]  len;
    logic [4:0]  day_clamp;
    op_t         op_next;

    // stall chain
    assign s2_ready    = !s2_valid_reg || op_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign in_ch.ready = s1_ready;

    // stage 1: saturate year and month, century by reciprocal multiply
    always_comb
    begin
        if (in_ch.load_year < YEAR_MIN)
            year_next = YEAR_MIN;
        else if (in_ch.load_year > YEAR_MAX)
            year_next = YEAR_MAX;
        else
            year_next = in_ch.load_year;
        if (in_ch.load_month < MONTH_MIN)
            month_next = MONTH_MIN;
        else if (in_ch.load_month > MONTH_MAX)
            month_next = MONTH_MAX;
        else
            month_next = in_ch.load_month;
        cent_prod = {13'b0, year_next} * {14'b0, DIV100_MUL};
    end

    // stage 2: year of century, leap, day clamp
    always_comb
    begin
        hund    = {7'b0, s1_cent_reg} * 14'd100;
        yr_diff = s1_year_reg - hund;
        yr_lo   = yr_diff[6:0];
        leap    = is_leap(s1_year_reg[1:0], yr_lo, s1_cent_reg[1:0]);
        len     = month_len(s1_month_reg, leap);
        if (s1_day_reg < DAY_MIN)
            day_clamp = DAY_MIN;
        else if (s1_day_reg > len)
            day_clamp = len;
        else
            day_clamp = s1_day_reg;
        op_next.cmd   = s1_cmd_reg;
        op_next.day   = day_clamp;
        op_next.month = s1_month_reg;
        op_next.year  = s1_year_reg;
        op_next.yr_lo = yr_lo;
        op_next.cent  = s1_cent_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_ch.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_ch.valid)
        begin
            s1_cmd_reg   <= cmd_t'(in_ch.cmd);
            s1_day_reg   <= in_ch.load_day;
            s1_month_reg <= month_next;
            s1_year_reg  <= year_next;
            s1_cent_reg  <= cent_prod[DIV100_SHIFT+6:DIV100_SHIFT];
        end
        if (s2_ready && s1_valid_reg)
            s2_op_reg <= op_next;
    end

    assign op       = s2_op_reg;
    assign op_valid = s2_valid_reg;

endmodule

### src/cds_queue.sv
// cds_queue: small fifo of classified items between front and back
// uses cds_pkg for the item type
module cds_queue
    import cds_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  op_t  wr_op,
    input  logic wr_valid,
    output logic wr_ready,
    output op_t  rd_op,
    output logic rd_valid,
    input  logic rd_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    op_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_op    = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_op;
    end

endmodule

### src/cds_exec.sv
// cds_exec: holds the current date and applies load / next / previous
// one item per cycle while dt_ready is high; uses cds_pkg
module cds_exec
    import cds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  op_t   op,
    input  logic  op_valid,
    output logic  op_ready,
    output date_t dt,
    output logic  dt_valid,
    input  logic  dt_ready
);

    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [13:0] year_reg;
    logic [6:0]  yr_lo_reg;
    logic [6:0]  cent_reg;
    logic        dt_valid_reg;
    logic        limit_reg;

    logic [4:0]  day_next;
    logic [3:0]  month_next;
    logic [13:0] year_next;
    logic [6:0]  yr_lo_next;
    logic [6:0]  cent_next;
    logic        limit_next;
    logic        leap;
    logic [4:0]  len;
    logic [3:0]  month_dec;
    logic        take;

    assign op_ready = !dt_valid_reg || dt_ready;
    assign take     = op_valid && op_ready;

    // step logic
    always_comb
    begin
        leap       = is_leap(year_reg[1:0], yr_lo_reg, cent_reg[1:0]);
        len        = month_len(month_reg, leap);
        month_dec  = month_reg - 1'b1;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        yr_lo_next = yr_lo_reg;
        cent_next  = cent_reg;
        limit_next = 1'b0;
        case (op.cmd)
            CMD_LOAD:
            begin
                day_next   = op.day;
                month_next = op.month;
                year_next  = op.year;
                yr_lo_next = op.yr_lo;
                cent_next  = op.cent;
            end
            CMD_NEXT:
            begin
                if (day_reg < len)
                    day_next = day_reg + 1'b1;
                else if (month_reg < MONTH_MAX)
                begin
                    day_next   = DAY_MIN;
                    month_next = month_reg + 1'b1;
                end
                else if (year_reg < YEAR_MAX)
                begin
                    day_next   = DAY_MIN;
                    month_next = MONTH_MIN;
                    year_next  = year_reg + 1'b1;
                    if (yr_lo_reg == YRLO_MAX)
                    begin
                        yr_lo_next = '0;
                        cent_next  = cent_reg + 1'b1;
                    end
                    else
                        yr_lo_next = yr_lo_reg + 1'b1;
                end
                else
                    limit_next = 1'b1;
            end
            CMD_PREV:
            begin
                if (day_reg > DAY_MIN)
                    day_next = day_reg - 1'b1;
                else if (month_reg > MONTH_MIN)
                begin
                    month_next = month_dec;
                    day_next   = month_len(month_dec, leap);
                end
                else if (year_reg > YEAR_MIN)
                begin
                    day_next   = DAY_MAX;
                    month_next = MONTH_MAX;
                    year_next  = year_reg - 1'b1;
                    if (yr_lo_reg == '0)
                    begin
                        yr_lo_next = YRLO_MAX;
                        cent_next  = cent_reg - 1'b1;
                    end
                    else
                        yr_lo_next = yr_lo_reg - 1'b1;
                end
                else
                    limit_next = 1'b1;
            end
            default:
            begin
                // unused code: date held, no flag
                limit_next = 1'b0;
            end
        endcase
    end

    // date state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg      <= DAY_MIN;
            month_reg    <= MONTH_MIN;
            year_reg     <= YEAR_RESET;
            yr_lo_reg    <= YRLO_RESET;
            cent_reg     <= CENT_RESET;
            dt_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
                yr_lo_reg <= yr_lo_next;
                cent_reg  <= cent_next;
            end
            if (op_ready)
                dt_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            limit_reg <= limit_next;
    end

    assign dt.day      = day_reg;
    assign dt.month    = month_reg;
    assign dt.year     = year_reg;
    assign dt.yr_lo    = yr_lo_reg;
    assign dt.cent     = cent_reg;
    assign dt.at_limit = limit_reg;
    assign dt_valid    = dt_valid_reg;

endmodule

### src/cds_calc.sv
// cds_calc: weekday and week of year for each stepped date, three stages
// uses cds_pkg and cds_out_if
module cds_calc
    import cds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  date_t     dt,
    input  logic      dt_valid,
    output logic      dt_ready,
    cds_out_if.source out_ch
);

    logic        w1_valid_reg;
    date_t       w1_dt_reg;
    logic [9:0]  w1_sum_d_reg;
    logic [9:0]  w1_sum_j_reg;
    logic [8:0]  w1_doy_reg;
    logic        w2_valid_reg;
    date_t       w2_dt_reg;
    logic [8:0]  w2_doy_reg;
    logic [2:0]  w2_wd_reg;
    logic [2:0]  w2_wd1_reg;
    logic        out_valid_reg;
    date_t       out_dt_reg;
    logic [2:0]  out_wd_reg;
    logic [5:0]  out_week_reg;

    logic        w1_ready;
    logic        w2_ready;
    logic        w3_ready;
    logic        leap;
    logic [6:0]  k_prev;
    logic [6:0]  j_prev;
    logic [3:0]  mz;
    logic [6:0]  kz;
    logic [6:0]  jz;
    logic [9:0]  sum_d_next;
    logic [9:0]  sum_j_next;
    logic [8:0]  doy_next;
    logic [9:0]  week_num;
    logic [7:0]  week_q;

    // stall chain
    assign w3_ready = !out_valid_reg || out_ch.ready;
    assign w2_ready = !w2_valid_reg || w3_ready;
    assign w1_ready = !w1_valid_reg || w2_ready;
    assign dt_ready = w1_ready;

    // stage 1: zeller sums for the date and for january 1, day of year
    always_comb
    begin
        leap = is_leap(dt.year[1:0], dt.yr_lo, dt.cent[1:0]);
        if (dt.yr_lo == '0)
        begin
            k_prev = YRLO_MAX;
            j_prev = dt.cent - 1'b1;
        end
        else
        begin
            k_prev = dt.yr_lo - 1'b1;
            j_prev = dt.cent;
        end
        if (dt.month < MONTH_MAR)
        begin
            mz = dt.month + MONTH_MAX;
            kz = k_prev;
            jz = j_prev;
        end
        else
        begin
            mz = dt.month;
            kz = dt.yr_lo;
            jz = dt.cent;
        end
        sum_d_next = zeller_sum(dt.day, mz, kz, jz);
        sum_j_next = zeller_sum(DAY_MIN, MONTH_JAN_Z, k_prev, j_prev);
        doy_next   = {4'b0, dt.day} + days_before(dt.month) +
                     {8'b0, (leap && (dt.month >= MONTH_MAR))};
    end

    // stage 3: week count = ceil((doy + wd1 - 1) / 7)
    always_comb
    begin
        week_num = {1'b0, w2_doy_reg} + {7'b0, w2_wd1_reg} + 10'd5;
        week_q   = div7(week_num);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_valid_reg  <= 1'b0;
            w2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (w1_ready)
                w1_valid_reg <= dt_valid;
            if (w2_ready)
                w2_valid_reg <= w1_valid_reg;
            if (w3_ready)
                out_valid_reg <= w2_valid_reg;
        end
    end

    // payload, stage 2 reduces the sums mod 7
    always_ff @(posedge clk)
    begin
        if (w1_ready && dt_valid)
        begin
            w1_dt_reg    <= dt;
            w1_sum_d_reg <= sum_d_next;
            w1_sum_j_reg <= sum_j_next;
            w1_doy_reg   <= doy_next;
        end
        if (w2_ready && w1_valid_reg)
        begin
            w2_dt_reg  <= w1_dt_reg;
            w2_doy_reg <= w1_doy_reg;
            w2_wd_reg  <= weekday_of(mod7(w1_sum_d_reg));
            w2_wd1_reg <= weekday_of(mod7(w1_sum_j_reg));
        end
        if (w3_ready && w2_valid_reg)
        begin
            out_dt_reg   <= w2_dt_reg;
            out_wd_reg   <= w2_wd_reg;
            out_week_reg <= week_q[5:0];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_day      = out_dt_reg.day;
    assign out_ch.out_month    = out_dt_reg.month;
    assign out_ch.out_year     = out_dt_reg.year;
    assign out_ch.weekday      = out_wd_reg;
    assign out_ch.week_of_year = out_week_reg;
    assign out_ch.at_limit     = out_dt_reg.at_limit;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench for calendar_date_stepper_top: directed and random date loads and steps,
// each result checked against a local calendar model
// depends on cds_pkg, cds_in_if / cds_out_if and the date stepper rtl
module testbench;
    import cds_pkg::*;

    localparam int unsigned FIRST_YEAR     = 1;
    localparam int unsigned LAST_YEAR      = 9999;
    localparam int unsigned LAST_MONTH     = 12;
    localparam int unsigned PIPE_LATENCY   = 6;
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned RANDOM_BEATS   = 1926;

    // one expected output beat
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  weekday;
        logic [5:0]  week;
        logic        at_limit;
    } date_result_t;

    logic clk;
    logic rst_n;

    cds_in_if  in_ch();
    cds_out_if out_ch();

    calendar_date_stepper_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // model of the stored date
    int unsigned cal_day;
    int unsigned cal_month;
    int unsigned cal_year;

    date_result_t expected_dates[$];
    date_result_t oldest_date;

    int unsigned burst_left;
    int unsigned n_items;
    int unsigned n_loads;
    int unsigned n_steps;
    int unsigned n_holds;
    int unsigned n_held_at_edge;
    int unsigned n_leap_days;
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned quiet_cycles;

    int unsigned rcv_cycle;
    int unsigned rcv_mode;
    int unsigned rcv_hold;
    logic [15:0] rcv_mask;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == 2)
            return is_leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // weekday by zeller's rule, jan and feb as months 13 and 14 of the year before
    function automatic int unsigned zeller_weekday(input int unsigned d, input int unsigned m,
                                                   input int unsigned y);
        int unsigned mm;
        int unsigned yy;
        int unsigned k;
        int unsigned j;
        int unsigned h;
        mm = m;
        yy = y;
        if (mm < 3)
        begin
            mm = mm + 12;
            yy = yy - 1;
        end
        k = yy % 100;
        j = yy / 100;
        h = (d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        // residue 0 is saturday, 1 sunday, then monday onward
        if (h == 0)
            return 6;
        if (h == 1)
            return 7;
        return h - 1;
    endfunction

    function automatic int unsigned week_number_of(input int unsigned d, input int unsigned m,
                                                   input int unsigned y);
        int unsigned doy;
        int unsigned i;
        doy = d;
        for (i = 1; i < m; i++)
            doy += days_in_month(i, y);
        return (doy + zeller_weekday(1, 1, y) - 1 + 6) / 7;
    endfunction

    // apply one command to the model date and build the expected beat
    function automatic date_result_t step_calendar(input cmd_t c, input logic [4:0] ld,
                                                   input logic [3:0] lm, input logic [13:0] ly);
        date_result_t r;
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned len;
        r.at_limit = 1'b0;
        case (c)
            CMD_LOAD:
            begin
                d = ld;
                m = lm;
                y = ly;
                if (y < FIRST_YEAR)
                    y = FIRST_YEAR;
                if (y > LAST_YEAR)
                    y = LAST_YEAR;
                if (m < 1)
                    m = 1;
                if (m > LAST_MONTH)
                    m = LAST_MONTH;
                len = days_in_month(m, y);
                if (d < 1)
                    d = 1;
                if (d > len)
                    d = len;
                cal_day = d;
                cal_month = m;
                cal_year = y;
            end
            CMD_NEXT:
            begin
                if (cal_day < days_in_month(cal_month, cal_year))
                    cal_day++;
                else if (cal_month < LAST_MONTH)
                begin
                    cal_day = 1;
                    cal_month++;
                end
                else if (cal_year < LAST_YEAR)
                begin
                    cal_day = 1;
                    cal_month = 1;
                    cal_year++;
                end
                else
                    r.at_limit = 1'b1;
            end
            CMD_PREV:
            begin
                if (cal_day > 1)
                    cal_day--;
                else if (cal_month > 1)
                begin
                    cal_month--;
                    cal_day = days_in_month(cal_month, cal_year);
                end
                else if (cal_year > FIRST_YEAR)
                begin
                    cal_year--;
                    cal_month = LAST_MONTH;
                    cal_day = 31;
                end
                else
                    r.at_limit = 1'b1;
            end
            default:
            begin
                // unused code leaves the date alone
            end
        endcase
        r.day = cal_day[4:0];
        r.month = cal_month[3:0];
        r.year = cal_year[13:0];
        r.weekday = 3'(zeller_weekday(cal_day, cal_month, cal_year));
        r.week = 6'(week_number_of(cal_day, cal_month, cal_year));
        return r;
    endfunction

    // send one beat; the sender may idle between bursts of random length
    task automatic send_beat(input cmd_t c, input logic [4:0] d, input logic [3:0] m,
                             input logic [13:0] y);
        int unsigned gap;
        date_result_t r;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 160)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.cmd <= c;
        in_ch.load_day <= d;
        in_ch.load_month <= m;
        in_ch.load_year <= y;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        r = step_calendar(c, d, m, y);
        expected_dates.push_back(r);
        n_items++;
        case (c)
            CMD_LOAD: n_loads++;
            CMD_NEXT: n_steps++;
            CMD_PREV: n_steps++;
            default:  n_holds++;
        endcase
        if (r.at_limit)
            n_held_at_edge++;
        if (r.month == 4'd2 && r.day == 5'd29)
            n_leap_days++;
    endtask

    // wait until every expected beat has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_dates.size() != 0)
            @(posedge clk);
    endtask

    // date right after reset, seen through the unused command code
    task automatic test_reset_date();
        send_beat(CMD_HOLD, 5'd0, 4'd0, 14'd0);
    endtask

    // loads at the field extremes and days past the month end
    task automatic test_load_saturation();
        send_beat(CMD_LOAD, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_LOAD, 5'd31, 4'd15, 14'd16383);
        send_beat(CMD_LOAD, 5'd31, 4'd2, 14'd2000);
        send_beat(CMD_LOAD, 5'd31, 4'd2, 14'd1900);
        send_beat(CMD_LOAD, 5'd31, 4'd4, 14'd2023);
        // leap year starting on a sunday ends in week 54
        send_beat(CMD_LOAD, 5'd31, 4'd12, 14'd2012);
    endtask

    // steps held at the first and last day of the year range
    task automatic test_year_range_edges();
        send_beat(CMD_LOAD, 5'd31, 4'd12, 14'd9999);
        send_beat(CMD_NEXT, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_PREV, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_NEXT, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_NEXT, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_LOAD, 5'd1, 4'd1, 14'd1);
        send_beat(CMD_PREV, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_NEXT, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_PREV, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_PREV, 5'd0, 4'd0, 14'd0);
    endtask

    // stepping back across month and year turns, leap and common february
    task automatic test_month_turns();
        send_beat(CMD_LOAD, 5'd1, 4'd3, 14'd2000);
        send_beat(CMD_PREV, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_LOAD, 5'd1, 4'd3, 14'd1900);
        send_beat(CMD_PREV, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_LOAD, 5'd1, 4'd1, 14'd2000);
        send_beat(CMD_PREV, 5'd0, 4'd0, 14'd0);
        send_beat(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    endtask

    // random loads followed by walks of steps, with some raw noise beats
    task automatic test_random_walks(input int unsigned count);
        int unsigned stop_at;
        int unsigned walk_len;
        int unsigned dir_mode;
        int unsigned pick;
        int unsigned i;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned len;
        cmd_t c;
        stop_at = n_items + count;
        while (n_items < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // raw beats over the full field ranges
                walk_len = $urandom_range(1, 4);
                for (i = 0; i < walk_len && n_items < stop_at; i++)
                    send_beat(cmd_t'($urandom_range(0, 3)), 5'($urandom), 4'($urandom),
                              14'($urandom));
            end
            else
            begin
                // year weighted toward range edges, centuries and leap years
                case ($urandom_range(0, 9))
                    0:       y = $urandom_range(1, 4);
                    1:       y = $urandom_range(9996, 9999);
                    2:       y = $urandom_range(1, 99) * 100;
                    3, 4:    y = $urandom_range(1, 2499) * 4;
                    default: y = $urandom_range(1, 9999);
                endcase
                pick = $urandom_range(0, 3);
                m = (pick == 0) ? 1 : (pick == 1) ? LAST_MONTH : $urandom_range(1, 12);
                len = days_in_month(m, y);
                pick = $urandom_range(0, 3);
                d = (pick == 0) ? len - $urandom_range(0, 2) :
                    (pick == 1) ? $urandom_range(1, 3) : $urandom_range(1, len);
                send_beat(CMD_LOAD, 5'(d), 4'(m), 14'(y));
                walk_len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 400)
                                                        : $urandom_range(1, 40);
                dir_mode = $urandom_range(0, 2);
                for (i = 0; i < walk_len && n_items < stop_at; i++)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        c = CMD_HOLD;
                    else if (dir_mode == 0)
                        c = (pick < 18) ? CMD_NEXT : CMD_PREV;
                    else if (dir_mode == 1)
                        c = (pick < 18) ? CMD_PREV : CMD_NEXT;
                    else
                        c = (pick < 10) ? CMD_NEXT : CMD_PREV;
                    // load fields are ignored on steps; keep them moving anyway
                    send_beat(c, 5'($urandom), 4'($urandom), 14'($urandom));
                end
            end
        end
    endtask

    // sender stops until the pipeline is empty, then carries on
    task automatic test_drain_pause();
        drain_results();
        send_beat(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            n_errors++;
        end
    endfunction

    // compare every output beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_checked++;
            if (expected_dates.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %0d-%0d-%0d",
                         $time, out_ch.out_year, out_ch.out_month, out_ch.out_day);
                n_errors++;
            end
            else
            begin
                oldest_date = expected_dates.pop_front();
                check_field("out_day", oldest_date.day, out_ch.out_day);
                check_field("out_month", oldest_date.month, out_ch.out_month);
                check_field("out_year", oldest_date.year, out_ch.out_year);
                check_field("weekday", oldest_date.weekday, out_ch.weekday);
                check_field("week_of_year", oldest_date.week, out_ch.week_of_year);
                check_field("at_limit", oldest_date.at_limit, out_ch.at_limit);
            end
        end
    end

    // receiver stall pattern; rcv_cycle sets when the mode and mask are redrawn
    initial
    begin
        out_ch.ready <= 1'b0;
        rcv_cycle = 0;
        rcv_mode = 0;
        rcv_hold = 0;
        rcv_mask = 16'hffff;
        forever
        begin
            @(posedge clk);
            if (rcv_cycle % 256 == 0)
            begin
                rcv_mode = $urandom_range(0, 3);
                rcv_mask = 16'($urandom) | 16'h0001;
            end
            rcv_cycle++;
            case (rcv_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= rcv_mask[4'(rcv_cycle % 16)];
                default:
                begin
                    if (rcv_hold != 0)
                    begin
                        rcv_hold--;
                        out_ch.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 19) == 0)
                    begin
                        rcv_hold = $urandom_range(1, 15);
                        out_ch.ready <= 1'b0;
                    end
                    else
                        out_ch.ready <= 1'b1;
                end
            endcase
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // reset, then the tests in turn
    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.cmd <= CMD_HOLD;
        in_ch.load_day <= 5'd0;
        in_ch.load_month <= 4'd0;
        in_ch.load_year <= 14'd0;
        cal_day = 1;
        cal_month = 1;
        cal_year = 2000;
        burst_left = 0;
        n_items = 0;
        n_loads = 0;
        n_steps = 0;
        n_holds = 0;
        n_held_at_edge = 0;
        n_leap_days = 0;
        n_checked = 0;
        n_errors = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_date();
        test_load_saturation();
        test_year_range_edges();
        test_month_turns();
        test_random_walks(RANDOM_BEATS / 2);
        test_drain_pause();
        test_random_walks(RANDOM_BEATS - RANDOM_BEATS / 2);

        drain_results();
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        $display("covered %0d beats: %0d loads, %0d steps, %0d unused codes; %0d results checked",
                 n_items, n_loads, n_steps, n_holds, n_checked);
        $display("steps held at the year range edge: %0d, leap days reached: %0d",
                 n_held_at_edge, n_leap_days);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
